// File: rtl/fir_audio_filter_defines.svh
// Assertion macros for the FIR audio filter.
// All of them sample on clk and are off while rst_n is low.
`ifndef FIR_AUDIO_FILTER_DEFINES_SVH
`define FIR_AUDIO_FILTER_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define FIRA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger.
`define FIRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fira_pkg.sv
`default_nettype none

package fira_pkg;

    // Field widths
    localparam int SAMPLE_W   = 24;
    localparam int FRAC_W     = 23;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int OP_W       = 2;
    localparam int COEF_IDX_W = 6;
    localparam int TAPS_W     = 7;

    typedef logic [OP_W-1:0]              op_t;
    typedef logic signed [SAMPLE_W-1:0]   sample_t;
    typedef logic [COEF_IDX_W-1:0]        coef_idx_t;
    typedef logic [TAPS_W-1:0]            taps_t;

    // Operation codes of an input word
    localparam op_t OP_SAMPLE = 2'd0;
    localparam op_t OP_PAD    = 2'd1;
    localparam op_t OP_COEF   = 2'd2;
    localparam op_t OP_CLEAR  = 2'd3;

    // Saturation limits, Q1.23
    localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
    localparam sample_t SAMPLE_MIN = 24'sh800000;

    // Controller to datapath
    typedef struct packed {
        logic load;       // latch the accepted word
        logic clr_step;   // one step of the clearing sweep
        logic coef_wr;    // write latched coefficient
        logic shift;      // write history at the pointer, advance it
        logic mac_issue;  // read one tap pair, start its MAC
        logic out_load;   // load output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic taps_zero;  // pass-through mode
        logic clr_last;   // last entry of the sweep
        logic issue_last; // last tap being issued
        logic pipe_busy;  // MAC pipeline still holds products
        logic out_busy;   // output register full and not taken
    } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/fira_in_if.sv
`default_nettype none

interface fira_in_if;
    import fira_pkg::*;

    logic      valid;
    logic      ready;
    op_t       op;
    sample_t   sample_in;
    coef_idx_t coeff_index;
    sample_t   coeff_value;

    modport source (output valid, output op, output sample_in, output coeff_index,
                    output coeff_value, input ready);
    modport sink   (input valid, input op, input sample_in, input coeff_index,
                    input coeff_value, output ready);
endinterface

`default_nettype wire

// File: rtl/fira_out_if.sv
`default_nettype none

interface fira_out_if;
    import fira_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// File: rtl/fira_cfg_if.sv
`default_nettype none

interface fira_cfg_if;
    import fira_pkg::*;

    logic  valid;
    logic  ready;
    taps_t tap_count;

    modport source (output valid, output tap_count, input ready);
    modport sink   (input valid, input tap_count, output ready);
endinterface

`default_nettype wire

// File: rtl/fir_audio_filter.sv
// Channel | Dir | Payload                                      | Word
// din     | in  | op, sample_in, coeff_index, coeff_value      | one operation
// dout    | out | sample_out                                   | one filtered sample
// cfg     | in  | tap_count                                    | register write
//
// Sample word: min(tap_count, MAX_TAPS) MACs, one MAC per cycle through the one read
// port of each store, then a drain, output load and history shift before the next
// accept; pass-through skips the MACs and the drain.
// After reset a sweep zeroes both stores; din is held off then.
// A result waits in the output register while din takes further words; the next
// sample then holds din off until that result is taken. cfg is always ready.
`default_nettype none
`include "fir_audio_filter_defines.svh"

module fir_audio_filter #(
    parameter int MAX_TAPS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    fira_in_if.sink           din,
    fira_out_if.source        dout,
    fira_cfg_if.sink          cfg
);
    import fira_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg.ready = 1'b1;

    // Sequencer
    fira_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_op    (din.op),
        .in_ready (din.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Stores, MAC pipeline and output register
    fira_dp #(
        .MAX_TAPS (MAX_TAPS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg.valid & cfg.ready),
        .cfg_tap_count (cfg.tap_count),
        .op            (din.op),
        .sample_in     (din.sample_in),
        .coeff_index   (din.coeff_index),
        .coeff_value   (din.coeff_value),
        .out_valid     (dout.valid),
        .out_ready     (dout.ready),
        .sample_out    (dout.sample_out)
    );

    // Checks
    `FIRA_ASSERT_SAME(a_ready_pipe_empty, din.ready, !stat.pipe_busy && !cmd.mac_issue, "MAC busy")
    `FIRA_ASSERT_SAME(a_load_when_free, cmd.out_load, !stat.out_busy, "result overwritten")
    `FIRA_ASSERT_NEXT(a_load_shows, cmd.out_load, dout.valid, "loaded result not presented")
    `FIRA_ASSERT_SAME(a_shift_alone, cmd.shift, !cmd.clr_step && !stat.pipe_busy, "shift overlap")

endmodule

`default_nettype wire

// File: rtl/fira_dp.sv
`default_nettype none

module fira_dp #(
    parameter int MAX_TAPS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fira_pkg::dp_cmd_t  cmd,
    output fira_pkg::dp_stat_t stat,
    input  logic               cfg_we,
    input  fira_pkg::taps_t    cfg_tap_count,
    input  fira_pkg::op_t      op,
    input  fira_pkg::sample_t  sample_in,
    input  fira_pkg::coef_idx_t coeff_index,
    input  fira_pkg::sample_t  coeff_value,
    output logic               out_valid,
    input  logic               out_ready,
    output fira_pkg::sample_t  sample_out
);
    import fira_pkg::*;

    localparam int HIST_DEPTH = MAX_TAPS - 1;
    localparam int HIST_SLOTS = (HIST_DEPTH > 0) ? HIST_DEPTH : 1;
    localparam int HAW        = (HIST_SLOTS > 1) ? $clog2(HIST_SLOTS) : 1;
    localparam int CAW        = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int ACC_W      = PROD_W + CAW;
    localparam int Q_W        = ACC_W - FRAC_W;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_W - 1);

    // Memories
    sample_t hist_mem [HIST_SLOTS];
    sample_t coef_mem [MAX_TAPS];

    // Control state
    taps_t            tap_count_reg;
    logic [HAW-1:0]   ptr_reg;
    logic [CAW-1:0]   clr_idx_reg;
    logic             clr_coef_reg;
    logic             v1_reg;
    logic             v2_reg;
    logic             out_valid_reg;

    // Payload
    op_t              op_reg;
    sample_t          x_reg;
    coef_idx_t        cidx_reg;
    sample_t          cval_reg;
    taps_t            taps_reg;
    taps_t            k_reg;
    logic [HAW-1:0]   rp_reg;
    logic             first1_reg;
    logic             first2_reg;
    sample_t          coef_rd_reg;
    sample_t          hist_rd_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    sample_t          out_data_reg;

    taps_t            taps_eff;
    logic             hist_we;
    logic [HAW-1:0]   hist_waddr;
    sample_t          hist_wdata;
    logic             coef_we;
    logic [CAW-1:0]   coef_waddr;
    sample_t          coef_wdata;
    logic [CAW-1:0]   coef_raddr;
    sample_t          mult_b;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [ACC_W-1:0]  rnd_sum;
    logic [Q_W-1:0]   rnd_q;
    logic [Q_W-SAMPLE_W:0] rnd_top;
    sample_t          sat_val;
    sample_t          result;

    // Effective tap count, limited to the coefficient store depth
    assign taps_eff = (int'(tap_count_reg) > MAX_TAPS) ? TAPS_W'(MAX_TAPS) : tap_count_reg;

    // Status
    assign stat.taps_zero  = (tap_count_reg == '0);
    assign stat.clr_last   = clr_coef_reg ? (int'(clr_idx_reg) == MAX_TAPS - 1)
                                          : (int'(clr_idx_reg) == HIST_SLOTS - 1);
    assign stat.issue_last = (k_reg == taps_reg - TAPS_W'(1));
    assign stat.pipe_busy  = v1_reg | v2_reg;
    assign stat.out_busy   = out_valid_reg & ~out_ready;

    // History write port: clearing sweep or shift-in
    assign hist_we    = (HIST_DEPTH > 0) &&
                        ((cmd.clr_step && (int'(clr_idx_reg) < HIST_DEPTH)) || cmd.shift);
    assign hist_waddr = cmd.clr_step ? HAW'(clr_idx_reg) : ptr_reg;
    assign hist_wdata = (cmd.clr_step || op_reg == OP_PAD) ? '0 : x_reg;

    // Coefficient write port: reset sweep or coefficient word
    assign coef_we    = (cmd.clr_step && clr_coef_reg) ||
                        (cmd.coef_wr && (int'(cidx_reg) < MAX_TAPS));
    assign coef_waddr = cmd.clr_step ? clr_idx_reg : CAW'(cidx_reg);
    assign coef_wdata = cmd.clr_step ? '0 : cval_reg;
    assign coef_raddr = CAW'(k_reg);

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_rd_reg <= hist_mem[rp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        coef_rd_reg <= coef_mem[coef_raddr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= '0;
            ptr_reg       <= '0;
            clr_idx_reg   <= '0;
            clr_coef_reg  <= 1'b1;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                tap_count_reg <= cfg_tap_count;
            end
            if (cmd.clr_step)
            begin
                ptr_reg     <= '0;
                clr_idx_reg <= stat.clr_last ? '0 : clr_idx_reg + CAW'(1);
                if (stat.clr_last)
                begin
                    clr_coef_reg <= 1'b0;
                end
            end
            else if (cmd.shift)
            begin
                ptr_reg <= (int'(ptr_reg) == HIST_SLOTS - 1) ? '0 : ptr_reg + HAW'(1);
            end
            v1_reg <= cmd.mac_issue;
            v2_reg <= v1_reg;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Word latch and tap address sequencing
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            x_reg    <= sample_in;
            cidx_reg <= coeff_index;
            cval_reg <= coeff_value;
            taps_reg <= taps_eff;
            k_reg    <= '0;
            rp_reg   <= (ptr_reg == '0) ? HAW'(HIST_SLOTS - 1) : ptr_reg - HAW'(1);
        end
        else if (cmd.mac_issue)
        begin
            k_reg <= k_reg + TAPS_W'(1);
            if (k_reg != '0)
            begin
                rp_reg <= (rp_reg == '0) ? HAW'(HIST_SLOTS - 1) : rp_reg - HAW'(1);
            end
        end
    end

    // MAC pipeline: read, multiply, accumulate
    assign mult_b = first1_reg ? x_reg : hist_rd_reg;
    assign prod_c = coef_rd_reg * mult_b;

    always_ff @(posedge clk)
    begin
        first1_reg <= (k_reg == '0);
        first2_reg <= first1_reg;
        prod_reg   <= prod_c;
        if (v2_reg)
        begin
            acc_reg <= first2_reg ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        end
    end

    // Round half up to Q1.23, then saturate
    assign rnd_sum = acc_reg + RND_HALF;
    assign rnd_q   = rnd_sum[ACC_W-1:FRAC_W];
    assign rnd_top = rnd_q[Q_W-1:SAMPLE_W-1];
    assign sat_val = ((rnd_top != '0) && (rnd_top != '1))
                   ? (rnd_q[Q_W-1] ? SAMPLE_MIN : SAMPLE_MAX)
                   : sample_t'(rnd_q[SAMPLE_W-1:0]);
    assign result  = (taps_reg == '0) ? x_reg : sat_val;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/fira_ctrl.sv
`default_nettype none

module fira_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  fira_pkg::op_t      in_op,
    output logic               in_ready,
    output fira_pkg::dp_cmd_t  cmd,
    input  fira_pkg::dp_stat_t stat
);
    import fira_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_COEF  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_MAC   = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid & in_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    unique case (in_op)
                        OP_SAMPLE: state_next = stat.taps_zero ? S_OUT : S_MAC;
                        OP_PAD:    state_next = S_SHIFT;
                        OP_COEF:   state_next = S_COEF;
                        OP_CLEAR:  state_next = S_CLEAR;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_COEF:
            begin
                cmd.coef_wr = 1'b1;
                state_next  = S_IDLE;
            end
            S_SHIFT:
            begin
                cmd.shift  = 1'b1;
                state_next = S_IDLE;
            end
            S_MAC:
            begin
                cmd.mac_issue = 1'b1;
                if (stat.issue_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_SHIFT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire
